/* hw/rtl/ttcw_pkg.sv */
// ttcw_pkg: shared types and constants for the text terminal character writer
// holds request codes, character codes, stream packing widths and the sequencer state type
// no dependencies

package ttcw_pkg;

    // request kinds carried on s_tuser
    localparam logic [1:0] REQ_PUT   = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // character codes with special handling
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSPACE = 8'h08;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // blank cell after reset: space with the reset attribute
    localparam logic [7:0]  ATTR_RESET = 8'h07;
    localparam logic [15:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

    // register map: register index is paddr[2]
    localparam logic REG_ATTR = 1'b0;

    // field widths
    localparam int REQ_W    = 2;
    localparam int CHAR_W   = 8;
    localparam int IDX_W    = 11;
    localparam int CURSOR_W = 11;
    localparam int CELL_W   = 16;

    // stream packing
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;
    localparam int S_PAD_W   = S_TDATA_W - CHAR_W - IDX_W;
    localparam int M_PAD_W   = M_TDATA_W - CURSOR_W - CELL_W;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_SCROLL_PRIME,
        ST_SCROLL,
        ST_BLANK,
        ST_DONE
    } state_t;

endpackage

/* hw/rtl/text_terminal_char_writer_core.sv */
// text_terminal_char_writer_core: character-cell console engine with screen buffer and cursor
// depends on ttcw_pkg; the screen buffer is an internal single-write, single-read memory

// A put, read or clear request is taken as one transaction on the s_ side and answers with
// exactly one transaction on the m_ side carrying the linear cursor position and, for reads,
// the cell contents. A small sequencer drives one memory write port, one registered read port
// and one address counter, and every request walks through it one at a time. A plain character,
// newline or backspace passes the execute and done states, an in-range read also a read state.
// A request that scrolls adds one priming read, a copy of ROWS*COLUMNS-COLUMNS cells at one
// cell per cycle, then COLUMNS blank writes; a clear adds ROWS*COLUMNS blank writes. After
// reset the buffer is cleared to blank cells in a pass over all ROWS*COLUMNS cells, during
// which s_tready stays low; configuration writes are taken at any time. A finished result
// waits in the output register while the next request is being worked on.

module text_terminal_char_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // s_tdata: char_code [7:0], cell_index [18:8], zero pad [23:19]
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ttcw_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [ttcw_pkg::REQ_W-1:0]      s_tuser,
    // m_tdata: cursor_position [10:0], read_data [26:11], zero pad [31:27]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ttcw_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int ROW_W  = $clog2(ROWS);
    localparam int COL_W  = $clog2(COLUMNS);

    localparam logic [ADDR_W-1:0] COLS_A      = ADDR_W'(COLUMNS);
    localparam logic [ADDR_W-1:0] COLS_A1     = ADDR_W'(COLUMNS + 1);
    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] LAST_BASE   = ADDR_W'(CELLS - COLUMNS);
    localparam logic [ADDR_W-1:0] COPY_LAST   = ADDR_W'(CELLS - COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);

    ttcw_pkg::state_t state_reg, state_next;

    logic [7:0]                     attr_reg;
    logic [ttcw_pkg::REQ_W-1:0]     req_reg;
    logic [ttcw_pkg::CHAR_W-1:0]    char_reg;
    logic [ttcw_pkg::IDX_W-1:0]     idx_reg;
    logic [ttcw_pkg::CELL_W-1:0]    res_data_reg, res_data_next;

    logic [ROW_W-1:0]               row_reg, row_next;
    logic [COL_W-1:0]               col_reg, col_next;
    logic [ADDR_W-1:0]              lin_reg, lin_next;
    logic [ADDR_W-1:0]              ptr_reg, ptr_next;

    logic                           m_valid_reg;
    logic [ttcw_pkg::CURSOR_W-1:0]  m_cursor_reg;
    logic [ttcw_pkg::CELL_W-1:0]    m_data_reg;

    logic [ttcw_pkg::CELL_W-1:0]    mem [CELLS];
    logic [ttcw_pkg::CELL_W-1:0]    rd_data_reg;
    logic                           mem_we, mem_re;
    logic [ADDR_W-1:0]              mem_wa, mem_ra;
    logic [ttcw_pkg::CELL_W-1:0]    mem_wd;

    logic                           accept;
    logic                           cfg_write;
    logic                           idx_ok;
    logic                           put_scroll;
    logic                           out_free;

    assign accept    = s_tvalid && s_tready;
    assign cfg_write = psel && penable && pwrite && pready;
    assign idx_ok    = 32'(idx_reg) < 32'(CELLS);
    assign out_free  = !m_valid_reg || m_tready;

    // a put scrolls when the cursor leaves the bottom row
    always_comb begin
        put_scroll = 1'b0;
        if (req_reg == ttcw_pkg::REQ_PUT && row_reg == LAST_ROW) begin
            if (char_reg == ttcw_pkg::CH_NEWLINE) begin
                put_scroll = 1'b1;
            end else if (char_reg != ttcw_pkg::CH_BACKSPACE && col_reg == LAST_COL) begin
                put_scroll = 1'b1;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ttcw_pkg::ST_INIT: begin
                if (ptr_reg == LAST_CELL) state_next = ttcw_pkg::ST_IDLE;
            end
            ttcw_pkg::ST_IDLE: begin
                if (accept) state_next = ttcw_pkg::ST_EXEC;
            end
            ttcw_pkg::ST_EXEC: begin
                priority if (req_reg == ttcw_pkg::REQ_CLEAR) begin
                    state_next = ttcw_pkg::ST_BLANK;
                end else if (req_reg == ttcw_pkg::REQ_READ && idx_ok) begin
                    state_next = ttcw_pkg::ST_READ;
                end else if (put_scroll) begin
                    state_next = ttcw_pkg::ST_SCROLL_PRIME;
                end else begin
                    state_next = ttcw_pkg::ST_DONE;
                end
            end
            ttcw_pkg::ST_READ:         state_next = ttcw_pkg::ST_DONE;
            ttcw_pkg::ST_SCROLL_PRIME: state_next = ttcw_pkg::ST_SCROLL;
            ttcw_pkg::ST_SCROLL: begin
                if (ptr_reg == COPY_LAST) state_next = ttcw_pkg::ST_BLANK;
            end
            ttcw_pkg::ST_BLANK: begin
                if (ptr_reg == LAST_CELL) state_next = ttcw_pkg::ST_DONE;
            end
            ttcw_pkg::ST_DONE: begin
                if (out_free) state_next = ttcw_pkg::ST_IDLE;
            end
            default: state_next = ttcw_pkg::ST_INIT;
        endcase
    end

    // memory port control
    always_comb begin
        mem_we = 1'b0;
        mem_wa = ptr_reg;
        mem_wd = {attr_reg, ttcw_pkg::CH_SPACE};
        mem_re = 1'b0;
        mem_ra = ptr_reg + COLS_A1;
        unique case (state_reg)
            ttcw_pkg::ST_INIT: begin
                mem_we = 1'b1;
                mem_wd = ttcw_pkg::RESET_CELL;
            end
            ttcw_pkg::ST_EXEC: begin
                if (req_reg == ttcw_pkg::REQ_PUT) begin
                    if (char_reg == ttcw_pkg::CH_BACKSPACE) begin
                        // blank the cell the cursor steps back onto
                        mem_we = 1'b1;
                        mem_wa = lin_next;
                    end else if (char_reg != ttcw_pkg::CH_NEWLINE) begin
                        mem_we = 1'b1;
                        mem_wa = lin_reg;
                        mem_wd = {attr_reg, char_reg};
                    end
                end
                if (req_reg == ttcw_pkg::REQ_READ && idx_ok) begin
                    mem_re = 1'b1;
                    mem_ra = ADDR_W'(idx_reg);
                end
            end
            ttcw_pkg::ST_SCROLL_PRIME: begin
                mem_re = 1'b1;
                mem_ra = COLS_A;
            end
            ttcw_pkg::ST_SCROLL: begin
                // write the row-below cell read last cycle, fetch the next one
                mem_we = 1'b1;
                mem_wd = rd_data_reg;
                mem_re = (ptr_reg != COPY_LAST);
            end
            ttcw_pkg::ST_BLANK: begin
                mem_we = 1'b1;
            end
            ttcw_pkg::ST_IDLE,
            ttcw_pkg::ST_READ,
            ttcw_pkg::ST_DONE: begin
                mem_we = 1'b0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // cursor, sweep counter and result data
    always_comb begin
        row_next      = row_reg;
        col_next      = col_reg;
        lin_next      = lin_reg;
        ptr_next      = ptr_reg;
        res_data_next = res_data_reg;
        unique case (state_reg)
            ttcw_pkg::ST_INIT: begin
                ptr_next = ptr_reg + ADDR_W'(1);
            end
            ttcw_pkg::ST_EXEC: begin
                res_data_next = '0;
                ptr_next      = '0;
                if (req_reg == ttcw_pkg::REQ_CLEAR) begin
                    row_next = '0;
                    col_next = '0;
                    lin_next = '0;
                end else if (req_reg == ttcw_pkg::REQ_PUT) begin
                    if (char_reg == ttcw_pkg::CH_NEWLINE) begin
                        col_next = '0;
                        row_next = row_reg + ROW_W'(1);
                        lin_next = lin_reg - ADDR_W'(col_reg) + COLS_A;
                    end else if (char_reg == ttcw_pkg::CH_BACKSPACE) begin
                        if (col_reg != '0) begin
                            col_next = col_reg - COL_W'(1);
                            lin_next = lin_reg - ADDR_W'(1);
                        end else if (row_reg != '0) begin
                            row_next = row_reg - ROW_W'(1);
                            col_next = LAST_COL;
                            lin_next = lin_reg - ADDR_W'(1);
                        end
                    end else begin
                        lin_next = lin_reg + ADDR_W'(1);
                        if (col_reg == LAST_COL) begin
                            col_next = '0;
                            row_next = row_reg + ROW_W'(1);
                        end else begin
                            col_next = col_reg + COL_W'(1);
                        end
                    end
                    if (put_scroll) begin
                        row_next = LAST_ROW;
                        col_next = '0;
                        lin_next = LAST_BASE;
                    end
                end
            end
            ttcw_pkg::ST_READ: begin
                res_data_next = rd_data_reg;
            end
            ttcw_pkg::ST_SCROLL: begin
                if (ptr_reg == COPY_LAST) begin
                    ptr_next = LAST_BASE;
                end else begin
                    ptr_next = ptr_reg + ADDR_W'(1);
                end
            end
            ttcw_pkg::ST_BLANK: begin
                ptr_next = ptr_reg + ADDR_W'(1);
            end
            ttcw_pkg::ST_IDLE,
            ttcw_pkg::ST_SCROLL_PRIME,
            ttcw_pkg::ST_DONE: begin
                ptr_next = ptr_reg;
            end
            default: begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // screen buffer
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_ra];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ttcw_pkg::ST_INIT;
            ptr_reg     <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            lin_reg     <= '0;
            attr_reg    <= ttcw_pkg::ATTR_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            lin_reg   <= lin_next;
            if (cfg_write && paddr[2] == ttcw_pkg::REG_ATTR) begin
                attr_reg <= pwdata[7:0];
            end
            if (state_reg == ttcw_pkg::ST_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        res_data_reg <= res_data_next;
        if (accept) begin
            req_reg  <= s_tuser;
            char_reg <= s_tdata[ttcw_pkg::CHAR_W-1:0];
            idx_reg  <= s_tdata[ttcw_pkg::CHAR_W +: ttcw_pkg::IDX_W];
        end
        if (state_reg == ttcw_pkg::ST_DONE && out_free) begin
            m_cursor_reg <= ttcw_pkg::CURSOR_W'(lin_reg);
            m_data_reg   <= res_data_reg;
        end
    end

    assign s_tready = (state_reg == ttcw_pkg::ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{ttcw_pkg::M_PAD_W{1'b0}}, m_data_reg, m_cursor_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == ttcw_pkg::REG_ATTR) ? {24'd0, attr_reg} : 32'd0;

endmodule

/* hw/rtl/ttcw_checker.sv */
// ttcw_checker: port-level assertions for the text terminal character writer
// depends on text_terminal_char_writer_core ports; bound to text_terminal_char_writer_core below

module ttcw_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // pad bits of a result are zero
    a_out_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[31:27] == 5'd0)
        else $error("result pad bits not zero");

    // one request at a time: ready drops after a transaction
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("ready held after accepted transaction");

    // reset empties the output register and blocks input
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("output valid or input ready after reset");

endmodule

bind text_terminal_char_writer_core ttcw_checker u_ttcw_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/sv/ttcw_console_sb_pkg.sv */
// ttcw_console_sb_pkg: screen/cursor predictor and result scoreboard for the console engine
// depends on ttcw_pkg for request codes, character codes and stream field widths

package ttcw_console_sb_pkg;

    import ttcw_pkg::*;

    localparam int TERM_COLS  = 80;
    localparam int TERM_ROWS  = 25;
    localparam int TERM_CELLS = TERM_COLS * TERM_ROWS;

    typedef struct packed {
        logic [CURSOR_W-1:0] cursor;
        logic [CELL_W-1:0]   cell_val;
    } console_reply_t;

    class console_scoreboard;
        logic [CELL_W-1:0] screen [TERM_CELLS];
        int unsigned       row;
        int unsigned       col;
        logic [7:0]        attr;
        console_reply_t    replies_due [$];
        int                mismatches;

        function new();
            attr       = ATTR_RESET;
            row        = 0;
            col        = 0;
            mismatches = 0;
            blank_screen();
        endfunction

        function void blank_screen();
            foreach (screen[i]) screen[i] = {attr, CH_SPACE};
        endfunction

        function void set_attribute(logic [7:0] value);
            attr = value;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function int failures();
            return mismatches;
        endfunction

        function void complain(string what, longint unsigned want, longint unsigned got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch on %s: expected 0x%0h, got 0x%0h", what, want, got);
        endfunction

        // update the screen model for one accepted request and queue its result
        function void note_request(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                   logic [IDX_W-1:0] idx);
            console_reply_t due;
            due.cell_val = '0;
            case (kind)
                REQ_PUT: begin
                    if (ch == CH_NEWLINE) begin
                        col = 0;
                        row++;
                    end else if (ch == CH_BACKSPACE) begin
                        if (col > 0) begin
                            col--;
                        end else if (row > 0) begin
                            row--;
                            col = TERM_COLS - 1;
                        end
                        screen[row * TERM_COLS + col] = {attr, CH_SPACE};
                    end else begin
                        screen[row * TERM_COLS + col] = {attr, ch};
                        col++;
                        if (col >= TERM_COLS) begin
                            col = 0;
                            row++;
                        end
                    end
                    // cursor ran off the bottom: shift every line up, blank the last one
                    if (row >= TERM_ROWS) begin
                        for (int i = 0; i < TERM_CELLS - TERM_COLS; i++)
                            screen[i] = screen[i + TERM_COLS];
                        for (int i = TERM_CELLS - TERM_COLS; i < TERM_CELLS; i++)
                            screen[i] = {attr, CH_SPACE};
                        row = TERM_ROWS - 1;
                        col = 0;
                    end
                end
                REQ_CLEAR: begin
                    blank_screen();
                    row = 0;
                    col = 0;
                end
                REQ_READ: begin
                    if (idx < TERM_CELLS) due.cell_val = screen[idx];
                end
                default: ;
            endcase
            due.cursor = CURSOR_W'(row * TERM_COLS + col);
            replies_due.push_back(due);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata);
            console_reply_t due;
            if (replies_due.size() == 0) begin
                complain("unsolicited result", 0, tdata);
                return;
            end
            due = replies_due.pop_front();
            if (tdata[CURSOR_W-1:0] !== due.cursor)
                complain("cursor_position", due.cursor, tdata[CURSOR_W-1:0]);
            if (tdata[CURSOR_W +: CELL_W] !== due.cell_val)
                complain("read_data", due.cell_val, tdata[CURSOR_W +: CELL_W]);
            if (tdata[M_TDATA_W-1 -: M_PAD_W] !== '0)
                complain("m_tdata pad", 0, tdata[M_TDATA_W-1 -: M_PAD_W]);
        endfunction
    endclass

endpackage

/* tb/sv/tb_text_terminal_char_writer_core.sv */
// tb_text_terminal_char_writer_core: stream-level testbench for the console engine core
// directed corner requests, then random text with scrolls, clears and reads under idling
// depends on ttcw_pkg, ttcw_console_sb_pkg and text_terminal_char_writer_core

module tb_text_terminal_char_writer_core;

    timeunit 1ns;
    timeprecision 1ps;

    import ttcw_pkg::*;
    import ttcw_console_sb_pkg::*;

    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [2:0] ATTR_ADDR    = {REG_ATTR, 2'b00};
    localparam int         HOLD_CYCLES  = 400;
    localparam int         DRAIN_CYCLES = TERM_CELLS + 100;
    localparam longint     CYCLE_LIMIT  = 6_000_000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic [REQ_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [2:0]            paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    console_scoreboard sb = new();
    bit                s_burst = 0;
    bit                m_burst = 0;
    bit                hold_request = 0;
    longint            cycle_count = 0;

    text_terminal_char_writer_core #(
        .COLUMNS(TERM_COLS),
        .ROWS   (TERM_ROWS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[text_terminal_char_writer_core] ERROR");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the transaction
    task automatic send_request(logic [REQ_W-1:0] kind, logic [CHAR_W-1:0] ch,
                                logic [IDX_W-1:0] idx);
        int gap;
        if ($urandom_range(0, 29) == 0) s_burst = !s_burst;
        gap = s_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tuser  = kind;
        s_tdata  = {{S_PAD_W{1'b0}}, idx, ch};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, ch, idx);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_attr(logic [7:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        paddr   = ATTR_ADDR;
        pwdata  = {24'd0, value};
        penable = 1'b0;
        @(negedge aclk);
        penable = 1'b1;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        sb.set_attribute(value);
    endtask

    // mostly printable traffic; nl_pct steers how fast the cursor walks down the screen
    task automatic run_random(int count, int nl_pct, int clear_pct);
        int                r;
        int                c;
        logic [REQ_W-1:0]  kind;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
        repeat (count) begin
            r   = $urandom_range(0, 99);
            c   = $urandom_range(0, 99);
            ch  = CHAR_W'($urandom_range(0, 255));
            idx = IDX_W'($urandom_range(0, 2047));
            if (r < 70) begin
                kind = REQ_PUT;
                if (c < nl_pct)
                    ch = CH_NEWLINE;
                else if (c < nl_pct + 6)
                    ch = CH_BACKSPACE;
            end else if (r < 92) begin
                kind = REQ_READ;
                if (c < 40)
                    idx = IDX_W'($urandom_range(TERM_CELLS - 3 * TERM_COLS, TERM_CELLS - 1));
                else if (c < 92)
                    idx = IDX_W'($urandom_range(0, TERM_CELLS - 1));
            end else if (r < 100 - clear_pct) begin
                kind = REQ_UNUSED;
            end else begin
                kind = REQ_CLEAR;
            end
            send_request(kind, ch, idx);
        end
    endtask

    // result side: random stalls, bursts without stalls, one long hold-off on request
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 0;
                m_tready     = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end
            if ($urandom_range(0, 29) == 0) m_burst = !m_burst;
            stall = m_burst ? 0 : $urandom_range(0, 10);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = REQ_PUT;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = ATTR_ADDR;
        pwdata   = '0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // corners at the reset attribute
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'hFF, 11'd1999);
        send_request(REQ_READ, 8'h00, 11'd2000);
        send_request(REQ_READ, 8'h00, 11'd2047);
        send_request(REQ_PUT, CH_BACKSPACE, 11'd0);   // top-left: blank in place
        send_request(REQ_PUT, 8'h00, 11'd2047);
        send_request(REQ_PUT, 8'hFF, 11'd0);
        send_request(REQ_PUT, 8'h0F, 11'd0);
        send_request(REQ_PUT, 8'h0E, 11'd0);
        send_request(REQ_PUT, 8'h41, 11'd0);
        send_request(REQ_PUT, CH_NEWLINE, 11'd0);
        send_request(REQ_PUT, CH_BACKSPACE, 11'd0);   // column 0: wraps to end of row 0
        send_request(REQ_PUT, CH_SPACE, 11'd0);
        send_request(REQ_UNUSED, 8'hFF, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd0);
        send_request(REQ_READ, 8'h00, 11'd79);
        send_request(REQ_READ, 8'h00, 11'd80);
        send_request(REQ_CLEAR, 8'hFF, 11'd2047);
        send_request(REQ_READ, 8'h00, 11'd5);
        send_request(REQ_READ, 8'h00, 11'd1999);

        wait_drained();
        write_attr(8'h00);
        run_random(150, 8, 3);

        // walk to the bottom row, then scroll-heavy text with one long result stall
        wait_drained();
        write_attr(8'hFF);
        repeat (TERM_ROWS) send_request(REQ_PUT, CH_NEWLINE, IDX_W'($urandom_range(0, 2047)));
        hold_request = 1;
        run_random(200, 30, 0);

        // long lines: row wraps and scrolls on wrap
        wait_drained();
        write_attr(8'($urandom_range(1, 254)));
        run_random(200, 2, 0);

        wait_drained();
        write_attr(8'($urandom_range(0, 255)));
        run_random(150, 10, 2);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.failures() == 0 && sb.pending() == 0)
            $display("[text_terminal_char_writer_core] OK");
        else
            $display("[text_terminal_char_writer_core] ERROR");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/ttcw_pkg.sv
hw/rtl/text_terminal_char_writer_core.sv
hw/rtl/ttcw_checker.sv
tb/sv/ttcw_console_sb_pkg.sv
tb/sv/tb_text_terminal_char_writer_core.sv
